>>> design/svx_pkg.sv
`timescale 1ns / 1ps
// Shared types, command and error codes and width helpers for the stack VM execute unit.
// Used by every module of the block except svx_div; depends on nothing.
package svx_pkg;

    localparam logic [5:0] CMD_PUSH_IMM = 6'd0;
    localparam logic [5:0] CMD_PUSH_REG = 6'd1;
    localparam logic [5:0] CMD_POP_REG  = 6'd2;
    localparam logic [5:0] CMD_DUP      = 6'd3;
    localparam logic [5:0] CMD_SWAP     = 6'd4;
    localparam logic [5:0] CMD_DROP     = 6'd5;
    localparam logic [5:0] CMD_SELECT   = 6'd6;
    localparam logic [5:0] CMD_ADD      = 6'd7;
    localparam logic [5:0] CMD_SUB      = 6'd8;
    localparam logic [5:0] CMD_MUL      = 6'd9;
    localparam logic [5:0] CMD_UDIV     = 6'd10;
    localparam logic [5:0] CMD_UREM     = 6'd11;
    localparam logic [5:0] CMD_SDIV     = 6'd12;
    localparam logic [5:0] CMD_SREM     = 6'd13;
    localparam logic [5:0] CMD_AND      = 6'd14;
    localparam logic [5:0] CMD_OR       = 6'd15;
    localparam logic [5:0] CMD_XOR      = 6'd16;
    localparam logic [5:0] CMD_NOT      = 6'd17;
    localparam logic [5:0] CMD_SHL      = 6'd18;
    localparam logic [5:0] CMD_LSHR     = 6'd19;
    localparam logic [5:0] CMD_ASHR     = 6'd20;
    localparam logic [5:0] CMD_EQ       = 6'd21;
    localparam logic [5:0] CMD_NE       = 6'd22;
    localparam logic [5:0] CMD_ULT      = 6'd23;
    localparam logic [5:0] CMD_ULE      = 6'd24;
    localparam logic [5:0] CMD_UGT      = 6'd25;
    localparam logic [5:0] CMD_UGE      = 6'd26;
    localparam logic [5:0] CMD_SLT      = 6'd27;
    localparam logic [5:0] CMD_SLE      = 6'd28;
    localparam logic [5:0] CMD_SGT      = 6'd29;
    localparam logic [5:0] CMD_SGE      = 6'd30;
    localparam logic [5:0] CMD_SEXT     = 6'd31;
    localparam logic [5:0] CMD_TRUNC    = 6'd32;
    localparam logic [5:0] CMD_TEST     = 6'd33;
    localparam logic [5:0] CMD_RET      = 6'd34;
    localparam logic [5:0] CMD_NOP      = 6'd35;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_WIDTH     = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd4;

    localparam logic [2:0] KIND_NOP    = 3'd0;
    localparam logic [2:0] KIND_PUSH   = 3'd1;
    localparam logic [2:0] KIND_DUP    = 3'd2;
    localparam logic [2:0] KIND_SWAP   = 3'd3;
    localparam logic [2:0] KIND_UNARY  = 3'd4;
    localparam logic [2:0] KIND_BINARY = 3'd5;
    localparam logic [2:0] KIND_SELECT = 3'd6;
    localparam logic [2:0] KIND_POP    = 3'd7;

    typedef struct packed {
        logic [5:0]  cmd;
        logic [6:0]  width;
        logic [63:0] imm;
        logic [3:0]  reg_index;
        logic [1:0]  npop;
        logic [1:0]  nres;
        logic [2:0]  kind;
        logic [2:0]  err;
    } svx_op_t;

    function automatic logic [63:0] width_mask(input logic [6:0] w);
        logic [63:0] m;
        if (w >= 7'd64)
            m = '1;
        else
            m = (64'd1 << w) - 64'd1;
        return m;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [6:0] w);
        logic [63:0] m;
        logic [6:0]  wm1;
        m   = width_mask(w);
        wm1 = w - 7'd1;
        return v[wm1[5:0]] ? (v | ~m) : (v & m);
    endfunction

endpackage

>>> design/svx_front.sv
`timescale 1ns / 1ps
// Front end: takes input transfers and classifies each command (pops, pushes, early errors).
// Depends on svx_pkg.
module svx_front
(
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [79:0]        s_axis_tdata,
    input  logic [5:0]         s_axis_tuser,
    output logic               q_valid,
    input  logic               q_ready,
    output svx_pkg::svx_op_t   q_op
);

    logic [5:0] cmd;
    logic [6:0] w;
    logic       need_w;

    assign cmd           = s_axis_tuser;
    assign w             = s_axis_tdata[6:0];
    assign s_axis_tready = q_ready;
    assign q_valid       = s_axis_tvalid;

    always_comb
    begin
        q_op           = '0;
        q_op.cmd       = cmd;
        q_op.width     = w;
        q_op.imm       = s_axis_tdata[70:7];
        q_op.reg_index = s_axis_tdata[74:71];
        q_op.err       = svx_pkg::ERR_NONE;
        need_w         = 1'b0;
        unique case (cmd) inside
            svx_pkg::CMD_PUSH_IMM, svx_pkg::CMD_PUSH_REG:
            begin
                q_op.nres = 2'd1;
                q_op.kind = svx_pkg::KIND_PUSH;
            end
            svx_pkg::CMD_POP_REG, svx_pkg::CMD_DROP, svx_pkg::CMD_TEST, svx_pkg::CMD_RET:
            begin
                q_op.npop = 2'd1;
                q_op.kind = svx_pkg::KIND_POP;
            end
            svx_pkg::CMD_DUP:
            begin
                q_op.npop = 2'd1;
                q_op.nres = 2'd2;
                q_op.kind = svx_pkg::KIND_DUP;
            end
            svx_pkg::CMD_SWAP:
            begin
                q_op.npop = 2'd2;
                q_op.nres = 2'd2;
                q_op.kind = svx_pkg::KIND_SWAP;
            end
            svx_pkg::CMD_SELECT:
            begin
                q_op.npop = 2'd3;
                q_op.nres = 2'd1;
                q_op.kind = svx_pkg::KIND_SELECT;
            end
            svx_pkg::CMD_NOT, svx_pkg::CMD_SEXT, svx_pkg::CMD_TRUNC:
            begin
                q_op.npop = 2'd1;
                q_op.nres = 2'd1;
                q_op.kind = svx_pkg::KIND_UNARY;
                need_w    = 1'b1;
            end
            [svx_pkg::CMD_ADD:svx_pkg::CMD_XOR], [svx_pkg::CMD_SHL:svx_pkg::CMD_SGE]:
            begin
                q_op.npop = 2'd2;
                q_op.nres = 2'd1;
                q_op.kind = svx_pkg::KIND_BINARY;
                need_w    = 1'b1;
            end
            svx_pkg::CMD_NOP:
            begin
                q_op.kind = svx_pkg::KIND_NOP;
            end
            default:
            begin
                q_op.kind = svx_pkg::KIND_NOP;
                q_op.err  = svx_pkg::ERR_UNKNOWN;
            end
        endcase
        if (need_w && (w == 7'd0 || w > 7'd64))
            q_op.err = svx_pkg::ERR_WIDTH;
    end

endmodule

>>> design/svx_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified commands between the front end and the execute back end.
// Depends on svx_pkg.
module svx_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  svx_pkg::svx_op_t   in_op,
    output logic               out_valid,
    input  logic               out_ready,
    output svx_pkg::svx_op_t   out_op
);

    svx_pkg::svx_op_t entries [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_op    = entries[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= in_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/svx_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Self-contained; used by the back end for div, rem and shift-amount reduction.
module svx_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic [63:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] shifted, diff;

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign shifted   = {rem_reg, quo_reg[63]};
    assign diff      = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[64] ? shifted[63:0] : diff[63:0];
            quo_reg <= {quo_reg[62:0], ~diff[64]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/svx_back.sv
`timescale 1ns / 1ps
// Execute back end: stack RAM with a three-entry top cache, register file, ALU sequencer and
// the output register. Depends on svx_pkg and svx_div.
module svx_back
#(
    parameter int NUM_REGS    = 16,
    parameter int STACK_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  svx_pkg::svx_op_t   q_op,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [79:0]        m_axis_tdata
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int PW1 = PW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_MUL0   = 4'd2;
    localparam logic [3:0] S_MUL1   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_MUL3   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_WR2    = 4'd8;
    localparam logic [3:0] S_RD1    = 4'd9;
    localparam logic [3:0] S_RD2    = 4'd10;

    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] regs_reg [NUM_REGS];

    logic [3:0]        state_reg, state_next;
    svx_pkg::svx_op_t  op_reg, op_next;
    logic [63:0]       t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [PW-1:0]     depth_reg, depth_next;
    logic [63:0]       res_reg, res_next;
    logic [63:0]       lo_reg, lo_next;
    logic [31:0]       hi_reg, hi_next;
    logic              out_valid_reg, out_valid_next;
    logic [79:0]       out_data_reg, out_data_next;
    logic [63:0]       rd_data_reg;

    logic              wr_en, rd_en, reg_wr;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [63:0]       wr_data;

    logic [63:0]       m, a, b, sa, sb, reg_rd, alu, div_res, newtop, value;
    logic [31:0]       mx, my;
    logic [63:0]       prod;
    logic [PW1-1:0]    room;
    logic [PW-1:0]     dn;
    logic [2:0]        err;
    logic              div_start, div_done;
    logic [63:0]       div_a, div_b, quo, rem;
    logic              is_shift, is_sdiv;

    svx_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign q_ready       = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);

    assign m  = svx_pkg::width_mask(op_reg.width);
    assign a  = t1_reg & m;
    assign b  = t0_reg & m;
    assign sa = svx_pkg::sign_ext(t1_reg, op_reg.width);
    assign sb = svx_pkg::sign_ext(t0_reg, op_reg.width);

    assign is_shift = (op_reg.cmd == svx_pkg::CMD_SHL) || (op_reg.cmd == svx_pkg::CMD_LSHR)
                      || (op_reg.cmd == svx_pkg::CMD_ASHR);
    assign is_sdiv  = (op_reg.cmd == svx_pkg::CMD_SDIV) || (op_reg.cmd == svx_pkg::CMD_SREM);
    assign div_a    = is_sdiv ? (sa[63] ? -sa : sa) : (is_shift ? t0_reg : a);
    assign div_b    = is_sdiv ? (sb[63] ? -sb : sb) : (is_shift ? {57'd0, op_reg.width} : b);

    assign prod = 64'(mx) * 64'(my);

    always_comb
    begin
        reg_rd = '0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (i == int'(op_reg.reg_index))
                reg_rd = regs_reg[i];
        end
    end

    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mx = a[31:0];
                my = b[63:32];
            end
            S_MUL2:
            begin
                mx = a[63:32];
                my = b[31:0];
            end
            default:
            begin
                mx = a[31:0];
                my = b[31:0];
            end
        endcase
    end

    always_comb
    begin
        case (op_reg.cmd)
            svx_pkg::CMD_PUSH_IMM: alu = op_reg.imm;
            svx_pkg::CMD_PUSH_REG: alu = reg_rd;
            svx_pkg::CMD_SELECT:   alu = (t2_reg != 64'd0) ? t1_reg : t0_reg;
            svx_pkg::CMD_ADD:      alu = (a + b) & m;
            svx_pkg::CMD_SUB:      alu = (a - b) & m;
            svx_pkg::CMD_AND:      alu = a & b;
            svx_pkg::CMD_OR:       alu = a | b;
            svx_pkg::CMD_XOR:      alu = a ^ b;
            svx_pkg::CMD_NOT:      alu = ~t0_reg & m;
            svx_pkg::CMD_EQ:       alu = {63'd0, a == b};
            svx_pkg::CMD_NE:       alu = {63'd0, a != b};
            svx_pkg::CMD_ULT:      alu = {63'd0, a < b};
            svx_pkg::CMD_ULE:      alu = {63'd0, a <= b};
            svx_pkg::CMD_UGT:      alu = {63'd0, a > b};
            svx_pkg::CMD_UGE:      alu = {63'd0, a >= b};
            svx_pkg::CMD_SLT:      alu = {63'd0, $signed(sa) < $signed(sb)};
            svx_pkg::CMD_SLE:      alu = {63'd0, $signed(sa) <= $signed(sb)};
            svx_pkg::CMD_SGT:      alu = {63'd0, $signed(sa) > $signed(sb)};
            svx_pkg::CMD_SGE:      alu = {63'd0, $signed(sa) >= $signed(sb)};
            svx_pkg::CMD_SEXT:     alu = sb;
            svx_pkg::CMD_TRUNC:    alu = b;
            default:               alu = t0_reg;
        endcase
    end

    always_comb
    begin
        case (op_reg.cmd)
            svx_pkg::CMD_UDIV: div_res = (b == 64'd0) ? 64'd0 : quo & m;
            svx_pkg::CMD_UREM: div_res = (b == 64'd0) ? 64'd0 : rem & m;
            svx_pkg::CMD_SDIV: div_res = (b == 64'd0) ? 64'd0 :
                                         ((sa[63] ^ sb[63]) ? -quo : quo) & m;
            svx_pkg::CMD_SREM: div_res = (b == 64'd0) ? 64'd0 : (sa[63] ? -rem : rem) & m;
            svx_pkg::CMD_SHL:  div_res = (a << rem[5:0]) & m;
            svx_pkg::CMD_LSHR: div_res = a >> rem[5:0];
            default:           div_res = 64'($signed(sa) >>> rem[5:0]) & m;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        depth_next     = depth_reg;
        res_next       = res_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = res_reg;
        rd_en          = 1'b0;
        rd_addr        = AW'(depth_reg - PW'(4));
        reg_wr         = 1'b0;
        div_start      = 1'b0;
        room           = PW1'(depth_reg) + PW1'(op_reg.nres) - PW1'(op_reg.npop);
        err            = op_reg.err;
        dn             = depth_reg;
        newtop         = t0_reg;
        value          = '0;

        if (err == svx_pkg::ERR_NONE && depth_reg < PW'(op_reg.npop))
            err = svx_pkg::ERR_UNDERFLOW;
        else if (err == svx_pkg::ERR_NONE && room > PW1'(STACK_DEPTH))
            err = svx_pkg::ERR_OVERFLOW;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    op_next    = q_op;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_next = alu;
                if (err != svx_pkg::ERR_NONE)
                begin
                    value          = (depth_reg != '0) ? t0_reg : 64'd0;
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b0, err, 1'b0, 1'b0, 9'(depth_reg), value};
                    state_next     = S_IDLE;
                end
                else if (op_reg.cmd == svx_pkg::CMD_MUL)
                    state_next = S_MUL0;
                else if (is_shift || op_reg.cmd == svx_pkg::CMD_UDIV
                         || op_reg.cmd == svx_pkg::CMD_UREM || is_sdiv)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_COMMIT;
            end
            S_MUL0:
            begin
                lo_next    = prod;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                hi_next    = prod[31:0];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                hi_next    = hi_reg + prod[31:0];
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                res_next   = (lo_reg + {hi_reg, 32'd0}) & m;
                state_next = S_COMMIT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_res;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
                case (op_reg.kind)
                    svx_pkg::KIND_PUSH, svx_pkg::KIND_DUP:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(depth_reg);
                        t0_next = res_reg;
                        t1_next = t0_reg;
                        t2_next = t1_reg;
                        dn      = depth_reg + PW'(1);
                        newtop  = res_reg;
                    end
                    svx_pkg::KIND_SWAP:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(depth_reg - PW'(1));
                        wr_data    = t1_reg;
                        t0_next    = t1_reg;
                        t1_next    = t0_reg;
                        newtop     = t1_reg;
                        state_next = S_WR2;
                    end
                    svx_pkg::KIND_UNARY:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(depth_reg - PW'(1));
                        t0_next = res_reg;
                        newtop  = res_reg;
                    end
                    svx_pkg::KIND_BINARY:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(depth_reg - PW'(2));
                        t0_next    = res_reg;
                        t1_next    = t2_reg;
                        rd_en      = (depth_reg >= PW'(4));
                        dn         = depth_reg - PW'(1);
                        newtop     = res_reg;
                        state_next = S_RD1;
                    end
                    svx_pkg::KIND_SELECT:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(depth_reg - PW'(3));
                        t0_next    = res_reg;
                        rd_en      = (depth_reg >= PW'(4));
                        dn         = depth_reg - PW'(2);
                        newtop     = res_reg;
                        state_next = S_RD1;
                    end
                    svx_pkg::KIND_POP:
                    begin
                        t0_next    = t1_reg;
                        t1_next    = t2_reg;
                        rd_en      = (depth_reg >= PW'(4));
                        dn         = depth_reg - PW'(1);
                        newtop     = t1_reg;
                        state_next = S_RD1;
                    end
                    default:
                    begin
                        newtop = t0_reg;
                    end
                endcase
                depth_next = dn;
                if (op_reg.cmd == svx_pkg::CMD_TEST || op_reg.cmd == svx_pkg::CMD_RET)
                    value = t0_reg;
                else
                    value = (dn != '0) ? newtop : 64'd0;
                reg_wr         = (op_reg.cmd == svx_pkg::CMD_POP_REG);
                out_valid_next = 1'b1;
                out_data_next  = {2'b0, svx_pkg::ERR_NONE,
                                  op_reg.cmd == svx_pkg::CMD_RET,
                                  op_reg.cmd == svx_pkg::CMD_TEST && t0_reg == 64'd0,
                                  9'(dn), value};
            end
            S_WR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(depth_reg - PW'(2));
                wr_data    = t1_reg;
                state_next = S_IDLE;
            end
            S_RD1:
            begin
                if (op_reg.kind == svx_pkg::KIND_SELECT)
                begin
                    t1_next    = rd_data_reg;
                    rd_en      = (depth_reg >= PW'(3));
                    rd_addr    = AW'(depth_reg - PW'(3));
                    state_next = S_RD2;
                end
                else
                begin
                    t2_next    = rd_data_reg;
                    state_next = S_IDLE;
                end
            end
            S_RD2:
            begin
                t2_next    = rd_data_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        res_reg      <= res_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (reg_wr && i == int'(op_reg.reg_index))
                    regs_reg[i] <= t0_reg;
            end
        end
    end

endmodule

>>> design/stack_vm_execute_unit.sv
`timescale 1ns / 1ps
// Top level of the stack VM execute unit: front end, command queue and execute back end.
// Depends on svx_pkg, svx_front, svx_queue and svx_back.
//
//  channel   direction  carries
//  s_axis    in         one decoded instruction per transfer
//  m_axis    out        one result per instruction
//
// An instruction passes from the queue to its result through fetch, check and commit; mul
// first runs on the shared 32x32 multiplier, and div, rem and shifts in the bit-serial
// divider. After commit come one or two stack RAM reads to refill the top cache after a net
// pop, or the second stack write of swap. A result not yet taken holds the next fetch.
// Up to two instructions queue while the back end works or the result waits.
// Reset empties the stack and clears the registers at once; there is no clearing pass.
module stack_vm_execute_unit
#(
    parameter int NUM_REGS    = 16,
    parameter int STACK_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // width[6:0], immediate[70:7], reg_index[74:71]
    input  logic [5:0]  s_axis_tuser,   // command[5:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // value[63:0], depth[72:64], was_zero[73],
                                        // returned[74], error[77:75]
);

    logic             f_valid, f_ready, b_valid, b_ready;
    svx_pkg::svx_op_t f_op, b_op;

    svx_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_op          (f_op)
    );

    svx_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_op    (b_op)
    );

    svx_back
    #(
        .NUM_REGS    (NUM_REGS),
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (b_valid),
        .q_ready       (b_ready),
        .q_op          (b_op),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> tb/tb_stack_vm_execute_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for stack_vm_execute_unit: queued instruction driver, result monitor
// and a stack machine predictor checked transfer by transfer. Depends on svx_pkg and the RTL.
module tb_stack_vm_execute_unit;

    typedef struct packed {
        logic [5:0]  cmd;
        logic [6:0]  width;
        logic [63:0] imm;
        logic [3:0]  reg_index;
    } instr_t;

    typedef struct packed {
        logic [63:0] value;
        logic [8:0]  depth;
        logic        was_zero;
        logic        returned;
        logic [2:0]  error;
    } outcome_t;

    localparam int LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [5:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    instr_t   pending_q[$];
    outcome_t outcome_q[$];
    instr_t   cur;
    int       total_items;
    int       accepted = 0;
    int       fails = 0;
    int       cycles = 0;
    int       gen_depth = 0;

    logic [63:0] vm_stack[256];
    int          vm_sp = 0;
    logic [63:0] vm_regs[16];

    stack_vm_execute_unit i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void op_shape(input logic [5:0] c, output int np, output int nr,
                                     output logic known);
        np = 0;
        nr = 0;
        known = 1'b1;
        case (c)
            svx_pkg::CMD_PUSH_IMM, svx_pkg::CMD_PUSH_REG: nr = 1;
            svx_pkg::CMD_POP_REG, svx_pkg::CMD_DROP, svx_pkg::CMD_TEST, svx_pkg::CMD_RET: np = 1;
            svx_pkg::CMD_DUP:
            begin
                np = 1;
                nr = 2;
            end
            svx_pkg::CMD_SWAP:
            begin
                np = 2;
                nr = 2;
            end
            svx_pkg::CMD_SELECT:
            begin
                np = 3;
                nr = 1;
            end
            svx_pkg::CMD_NOT, svx_pkg::CMD_SEXT, svx_pkg::CMD_TRUNC:
            begin
                np = 1;
                nr = 1;
            end
            svx_pkg::CMD_NOP: ;
            default:
            begin
                if (c >= svx_pkg::CMD_ADD && c <= svx_pkg::CMD_SGE)
                begin
                    np = 2;
                    nr = 1;
                end
                else
                    known = 1'b0;
            end
        endcase
    endfunction

    function automatic logic [2:0] op_error(input instr_t it, input int depth);
        int   np;
        int   nr;
        logic known;
        op_shape(it.cmd, np, nr, known);
        if (!known)
            return svx_pkg::ERR_UNKNOWN;
        if (it.cmd >= svx_pkg::CMD_ADD && it.cmd <= svx_pkg::CMD_TRUNC
            && (it.width == 0 || it.width > 64))
            return svx_pkg::ERR_WIDTH;
        if (depth < np)
            return svx_pkg::ERR_UNDERFLOW;
        if (depth - np + nr > 256)
            return svx_pkg::ERR_OVERFLOW;
        return svx_pkg::ERR_NONE;
    endfunction

    function automatic logic [63:0] vm_peek(input int k);
        return (k < vm_sp) ? vm_stack[vm_sp - 1 - k] : 64'd0;
    endfunction

    function automatic logic [63:0] mask_of(input int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] sx(input logic [63:0] v, input int w);
        logic [63:0] m;
        m = mask_of(w);
        v = v & m;
        return v[w - 1] ? (v | ~m) : v;
    endfunction

    task automatic execute_instr(input instr_t it);
        outcome_t    o;
        logic [2:0]  e;
        int          np;
        int          nr;
        int          w;
        int          sh;
        logic        known;
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        logic [63:0] r0;
        logic [63:0] r1;
        logic        lt;
        o = '{64'd0, 9'd0, 1'b0, 1'b0, svx_pkg::ERR_NONE};
        e = op_error(it, vm_sp);
        t0 = vm_peek(0);
        t1 = vm_peek(1);
        t2 = vm_peek(2);
        if (e != svx_pkg::ERR_NONE)
        begin
            o.value = t0;
            o.depth = vm_sp[8:0];
            o.error = e;
            outcome_q.push_back(o);
            return;
        end
        op_shape(it.cmd, np, nr, known);
        w = it.width;
        m = (it.cmd >= svx_pkg::CMD_ADD && it.cmd <= svx_pkg::CMD_TRUNC) ? mask_of(w) : '1;
        b = t0 & m;
        a = t1 & m;
        sa = 64'd0;
        sb = 64'd0;
        sh = 0;
        if (it.cmd >= svx_pkg::CMD_ADD && it.cmd <= svx_pkg::CMD_TRUNC)
        begin
            sa = sx(t1, w);
            sb = sx(t0, w);
            sh = int'(t0 % 64'(w));
        end
        r0 = 64'd0;
        r1 = 64'd0;
        lt = $signed(sa) < $signed(sb);
        case (it.cmd)
            svx_pkg::CMD_PUSH_IMM: r0 = it.imm;
            svx_pkg::CMD_PUSH_REG: r0 = vm_regs[it.reg_index];
            svx_pkg::CMD_POP_REG:  vm_regs[it.reg_index] = t0;
            svx_pkg::CMD_DUP:
            begin
                r0 = t0;
                r1 = t0;
            end
            svx_pkg::CMD_SWAP:
            begin
                r0 = t0;
                r1 = t1;
            end
            svx_pkg::CMD_SELECT: r0 = (t2 != 0) ? t1 : t0;
            svx_pkg::CMD_ADD:    r0 = (a + b) & m;
            svx_pkg::CMD_SUB:    r0 = (a - b) & m;
            svx_pkg::CMD_MUL:    r0 = (a * b) & m;
            svx_pkg::CMD_UDIV:   r0 = (b != 0) ? (a / b) & m : 64'd0;
            svx_pkg::CMD_UREM:   r0 = (b != 0) ? (a % b) & m : 64'd0;
            svx_pkg::CMD_SDIV, svx_pkg::CMD_SREM:
            begin
                ua = sa[63] ? -sa : sa;
                ub = sb[63] ? -sb : sb;
                if (sb == 0)
                    q = 64'd0;
                else if (sb == '1)
                    q = (it.cmd == svx_pkg::CMD_SDIV) ? -sa : 64'd0;
                else if (it.cmd == svx_pkg::CMD_SDIV)
                begin
                    q = ua / ub;
                    if (sa[63] != sb[63])
                        q = -q;
                end
                else
                begin
                    q = ua % ub;
                    if (sa[63])
                        q = -q;
                end
                r0 = q & m;
            end
            svx_pkg::CMD_AND:   r0 = a & b;
            svx_pkg::CMD_OR:    r0 = a | b;
            svx_pkg::CMD_XOR:   r0 = a ^ b;
            svx_pkg::CMD_NOT:   r0 = ~t0 & m;
            svx_pkg::CMD_SHL:   r0 = (a << sh) & m;
            svx_pkg::CMD_LSHR:  r0 = a >> sh;
            svx_pkg::CMD_ASHR:  r0 = sa[63] ? (~((~sa) >> sh)) & m : (sa >> sh) & m;
            svx_pkg::CMD_EQ:    r0 = 64'(a == b);
            svx_pkg::CMD_NE:    r0 = 64'(a != b);
            svx_pkg::CMD_ULT:   r0 = 64'(a < b);
            svx_pkg::CMD_ULE:   r0 = 64'(a <= b);
            svx_pkg::CMD_UGT:   r0 = 64'(a > b);
            svx_pkg::CMD_UGE:   r0 = 64'(a >= b);
            svx_pkg::CMD_SLT:   r0 = 64'(lt);
            svx_pkg::CMD_SLE:   r0 = 64'(lt || sa == sb);
            svx_pkg::CMD_SGT:   r0 = 64'(!lt && sa != sb);
            svx_pkg::CMD_SGE:   r0 = 64'(!lt);
            svx_pkg::CMD_SEXT:  r0 = sb;
            svx_pkg::CMD_TRUNC: r0 = t0 & m;
            svx_pkg::CMD_TEST:  o.was_zero = (t0 == 0);
            svx_pkg::CMD_RET:   o.returned = 1'b1;
            default: ;
        endcase
        vm_sp = vm_sp - np;
        if (nr > 0)
        begin
            vm_stack[vm_sp] = r0;
            vm_sp++;
        end
        if (nr > 1)
        begin
            vm_stack[vm_sp] = r1;
            vm_sp++;
        end
        o.value = (it.cmd == svx_pkg::CMD_TEST || it.cmd == svx_pkg::CMD_RET) ? t0 : vm_peek(0);
        o.depth = vm_sp[8:0];
        outcome_q.push_back(o);
    endtask

    task automatic add_instr(input logic [5:0] c, input logic [6:0] w, input logic [63:0] imm,
                             input logic [3:0] r);
        instr_t it;
        int     np;
        int     nr;
        logic   known;
        it = '{c, w, imm, r};
        pending_q.push_back(it);
        if (op_error(it, gen_depth) == svx_pkg::ERR_NONE)
        begin
            op_shape(c, np, nr, known);
            gen_depth = gen_depth - np + nr;
        end
    endtask

    function automatic logic [63:0] pick_value();
        int k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 6))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1 << k;
            3: return (64'd1 << k) - 64'd1;
            4: return 64'($urandom_range(0, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [6:0] pick_width();
        case ($urandom_range(0, 9))
            0: return 7'd64;
            1: return 7'd1;
            2: return 7'($urandom_range(1, 8));
            3: return 7'(8 << $urandom_range(0, 3));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [79:0] pack_instr(input instr_t it);
        return {5'd0, it.reg_index, it.imm, it.width};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                execute_instr(cur);
                accepted <= accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_q.size() > 0 &&
                    $urandom_range(0, 99) >= ((accepted * 3 < total_items) ? 9 :
                                              (accepted * 3 < total_items * 2) ? 49 : 0))
                begin
                    cur = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_instr(cur);
                    s_axis_tuser  <= cur.cmd;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t exp_o;
        outcome_t got;
        if (rst_n)
        begin
            m_axis_tready <= $urandom_range(0, 99) >= ((accepted * 3 < total_items) ? 49 :
                                                      (accepted * 3 < total_items * 2) ? 9 : 0);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value    = m_axis_tdata[63:0];
                got.depth    = m_axis_tdata[72:64];
                got.was_zero = m_axis_tdata[73];
                got.returned = m_axis_tdata[74];
                got.error    = m_axis_tdata[77:75];
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    fails++;
                end
                else
                begin
                    exp_o = outcome_q.pop_front();
                    if (got.value !== exp_o.value)
                        $display("%0t: value exp %h got %h", $time, exp_o.value, got.value);
                    if (got.depth !== exp_o.depth)
                        $display("%0t: depth exp %0d got %0d", $time, exp_o.depth, got.depth);
                    if (got.was_zero !== exp_o.was_zero)
                        $display("%0t: was_zero exp %b got %b", $time, exp_o.was_zero,
                                 got.was_zero);
                    if (got.returned !== exp_o.returned)
                        $display("%0t: returned exp %b got %b", $time, exp_o.returned,
                                 got.returned);
                    if (got.error !== exp_o.error)
                        $display("%0t: error exp %0d got %0d", $time, exp_o.error, got.error);
                    if (got !== exp_o)
                        fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int          sel;
        logic [5:0]  c;
        foreach (vm_regs[i])
            vm_regs[i] = 64'd0;

        // directed: empty stack, extremes, special divisors, errors
        add_instr(svx_pkg::CMD_DROP, 7'd0, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_PUSH_REG, 7'd127, 64'd0, 4'd15);
        add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, '1, 4'd0);
        add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, 64'h8000_0000_0000_0000, 4'd0);
        add_instr(svx_pkg::CMD_SDIV, 7'd64, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, '1, 4'd0);
        add_instr(svx_pkg::CMD_SREM, 7'd64, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_UDIV, 7'd64, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, 64'd5, 4'd0);
        add_instr(svx_pkg::CMD_ADD, 7'd0, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_ADD, 7'd65, 64'd0, 4'd0);
        add_instr(6'd36, 7'd1, 64'd0, 4'd0);
        add_instr(6'd63, 7'd1, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_POP_REG, 7'd0, 64'd0, 4'd15);
        add_instr(svx_pkg::CMD_PUSH_REG, 7'd0, 64'd0, 4'd15);
        add_instr(svx_pkg::CMD_DUP, 7'd0, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_SHL, 7'd3, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, 64'd13, 4'd0);
        add_instr(svx_pkg::CMD_ASHR, 7'd5, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_SEXT, 7'd1, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_TEST, 7'd0, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_NOP, 7'd0, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_RET, 7'd0, 64'd0, 4'd0);
        add_instr(svx_pkg::CMD_RET, 7'd0, 64'd0, 4'd0);

        n = 0;
        while (pending_q.size() < 1750)
        begin
            if (n == 800)
            begin
                // fill to overflow, then drain to underflow
                while (gen_depth < 256)
                    add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, pick_value(), 4'($urandom));
                add_instr(svx_pkg::CMD_PUSH_IMM, 7'd0, pick_value(), 4'd0);
                add_instr(svx_pkg::CMD_DUP, 7'd0, 64'd0, 4'd0);
                add_instr(svx_pkg::CMD_SWAP, 7'd0, 64'd0, 4'd0);
                while (gen_depth > 0)
                    add_instr(svx_pkg::CMD_DROP, 7'($urandom), 64'd0, 4'd0);
                add_instr(svx_pkg::CMD_SELECT, 7'd0, 64'd0, 4'd0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 10)
                add_instr(6'($urandom), 7'($urandom), {$urandom, $urandom}, 4'($urandom));
            else if (gen_depth < 3 || (gen_depth < 12 && sel < 45))
            begin
                if ($urandom_range(0, 3) == 0)
                    add_instr(svx_pkg::CMD_PUSH_REG, 7'($urandom), 64'd0, 4'($urandom));
                else
                    add_instr(svx_pkg::CMD_PUSH_IMM, 7'($urandom), pick_value(), 4'($urandom));
            end
            else
            begin
                c = 6'($urandom_range(1, 35));
                add_instr(c, ($urandom_range(0, 19) == 0) ? 7'($urandom) : pick_width(),
                          {$urandom, $urandom}, 4'($urandom));
            end
            n++;
        end
        total_items = pending_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0);
        repeat (200) @(posedge clk);
        if (fails == 0 && outcome_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
design/svx_pkg.sv
design/svx_front.sv
design/svx_queue.sv
design/svx_div.sv
design/svx_back.sv
design/stack_vm_execute_unit.sv
tb/tb_stack_vm_execute_unit.sv
